### rtl/core/bfp_pkg.sv
// ----------------------------------------------------------------------------
// Bit field packer package
// Shared state type, constants, mode codes and a helper function for the bit field packer.
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam int MAX_FIELD_BITS_DEF = 64;

    localparam logic [1:0] MODE_BE    = 2'd0;
    localparam logic [1:0] MODE_LE    = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } bfp_state_t;

    // Mask with the low n bits set; n of 64 or more sets all bits.
    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n[6]) begin
            m = '1;
        end else begin
            m = (64'd1 << n[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

### rtl/core/bit_field_packer_unit.sv
// ----------------------------------------------------------------------------
// Bit field packer unit
// Packs fields of up to MAX_FIELD_BITS bits into an MSB-first byte stream,
// one extracted chunk of at most eight bits per cycle unless an emitting step waits on the output.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Word
//  s_       in         s_valid / s_ready  s_mode, s_value, s_field_bits
//  m_       out        m_valid / m_ready  m_out_byte, m_byte_valid, m_status, m_last
//
//  An item is loaded and then worked off in steps of the shared 8-bit
//  extract and shift unit, one step per chunk of at most eight bits.
//  The block takes no new item until the last step of the current one is done.
//  A step that produces a word waits while the output register is still full.
//  Reset is synchronous and active low.
//
module bit_field_packer_unit #(
    parameter int MAX_FIELD_BITS = bfp_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [63:0] s_value,
    input  logic [6:0]  s_field_bits,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_status,
    output logic        m_last
);

    localparam int RW = $clog2(MAX_FIELD_BITS + 1);
    localparam int NB = MAX_FIELD_BITS / 8;
    localparam logic [6:0]    MAX_W = 7'(MAX_FIELD_BITS);
    localparam logic [RW-1:0] MAX_R = RW'(MAX_FIELD_BITS);

    localparam logic [1:0] MODE_BE_C    = bfp_pkg::MODE_BE;
    localparam logic [1:0] MODE_LE_C    = bfp_pkg::MODE_LE;
    localparam logic [1:0] MODE_FLUSH_C = bfp_pkg::MODE_FLUSH;

    bfp_pkg::bfp_state_t state_reg, state_next;

    logic [MAX_FIELD_BITS-1:0] sh_reg, sh_next;
    logic [RW-1:0]             rem_reg, rem_next;
    logic [7:0]                pend_reg, pend_next;
    logic [2:0]                fill_reg, fill_next;
    logic                      emitted_reg, emitted_next;
    logic                      stat_reg, stat_next;

    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_byte_reg, m_byte_next;
    logic                      m_bv_reg, m_bv_next;
    logic                      m_status_reg, m_status_next;
    logic                      m_last_reg, m_last_next;

    logic                      accept;
    logic [6:0]                w_sat;
    logic [6:0]                le_bits;
    logic                      be_over;
    logic                      le_over;
    logic [MAX_FIELD_BITS-1:0] val_t;
    logic [MAX_FIELD_BITS-1:0] sh_be;
    logic [MAX_FIELD_BITS-1:0] sh_le;
    logic [3:0]                avail;
    logic [3:0]                k;
    logic [3:0]                fill_sum;
    logic                      complete;
    logic [RW-1:0]             rem_after;
    logic [7:0]                byte_new;
    logic                      emit;
    logic                      out_free;
    logic                      step_go;
    logic                      done;

    // Load path.
    always_comb begin
        w_sat   = (s_field_bits > MAX_W) ? MAX_W : s_field_bits;
        le_bits = {w_sat[6:3], 3'b000};
        be_over = |(s_value & ~bfp_pkg::low_mask(w_sat));
        le_over = |(s_value & ~bfp_pkg::low_mask(le_bits));
        val_t   = s_value[MAX_FIELD_BITS-1:0];
        sh_be   = val_t << (MAX_R - RW'(w_sat));
        sh_le   = '0;
        for (int i = 0; i < NB; i++) begin
            if (w_sat[6:3] > 4'(i)) begin
                sh_le[MAX_FIELD_BITS-1-8*i -: 8] = s_value[8*i +: 8];
            end
        end
    end

    // One step of the shared extract and shift unit.
    always_comb begin
        avail     = 4'd8 - {1'b0, fill_reg};
        k         = (rem_reg < RW'(avail)) ? rem_reg[3:0] : avail;
        fill_sum  = {1'b0, fill_reg} + k;
        complete  = fill_sum[3];
        rem_after = rem_reg - RW'(k);
        byte_new  = pend_reg | (sh_reg[MAX_FIELD_BITS-1 -: 8] >> fill_reg);
        emit      = complete || (rem_after == '0 && !emitted_reg);
        out_free  = !m_valid_reg || m_ready;
        step_go   = (state_reg == bfp_pkg::ST_RUN) && (!emit || out_free);
        done      = step_go && (rem_after == '0);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = bfp_pkg::ST_RUN;
                end
            end
            bfp_pkg::ST_RUN: begin
                if (done) begin
                    state_next = bfp_pkg::ST_IDLE;
                end
            end
            default: state_next = bfp_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath next values.
    always_comb begin
        s_ready      = (state_reg == bfp_pkg::ST_IDLE);
        accept       = s_valid && s_ready;

        sh_next      = sh_reg;
        rem_next     = rem_reg;
        pend_next    = pend_reg;
        fill_next    = fill_reg;
        emitted_next = emitted_reg;
        stat_next    = stat_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_bv_next     = m_bv_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        if (accept) begin
            emitted_next = 1'b0;
            sh_next      = '0;
            rem_next     = '0;
            stat_next    = 1'b0;
            unique case (s_mode)
                MODE_BE_C: begin
                    stat_next = be_over;
                    if (!be_over) begin
                        sh_next  = sh_be;
                        rem_next = RW'(w_sat);
                    end
                end
                MODE_LE_C: begin
                    stat_next = le_over;
                    sh_next   = sh_le;
                    rem_next  = RW'(le_bits);
                end
                MODE_FLUSH_C: begin
                    if (fill_reg != 3'd0) begin
                        rem_next = RW'(avail);
                    end
                end
                default: begin
                    rem_next = '0;
                end
            endcase
        end else if (step_go) begin
            sh_next      = sh_reg << k;
            rem_next     = rem_after;
            emitted_next = emitted_reg || emit;
            if (complete) begin
                pend_next = 8'd0;
                fill_next = 3'd0;
            end else begin
                pend_next = byte_new;
                fill_next = fill_sum[2:0];
            end
            if (emit) begin
                m_valid_next  = 1'b1;
                m_byte_next   = complete ? byte_new : 8'd0;
                m_bv_next     = complete;
                m_status_next = stat_reg;
                m_last_next   = complete ? (rem_after < RW'(8)) : 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfp_pkg::ST_IDLE;
            pend_reg    <= 8'd0;
            fill_reg    <= 3'd0;
            emitted_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            fill_reg    <= fill_next;
            emitted_reg <= emitted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        stat_reg     <= stat_next;
        m_byte_reg   <= m_byte_next;
        m_bv_reg     <= m_bv_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_byte_valid = m_bv_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == bfp_pkg::ST_RUN)
        else $error("accepted word did not start the sequencer");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_last && m_out_byte == 8'd0)
        else $error("word without a byte is not a final zero word");

    a_run_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bfp_pkg::ST_RUN && rem_reg == '0 |-> !emitted_reg)
        else $error("sequencer running with nothing left to emit");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && emit && m_last_next && !complete |-> done)
        else $error("final word produced before the item finished");

endmodule
